FILE: rtl/core/block_hash_chain_store_macros.svh
// Assertion helpers shared by the hash chain store modules.
`ifndef BLOCK_HASH_CHAIN_STORE_MACROS_SVH
`define BLOCK_HASH_CHAIN_STORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BHCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BHCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bhcs_pkg.sv
`default_nettype none

package bhcs_pkg;

   // Store geometry
   localparam int DEF_MAX_BLOCKS = 65536;
   localparam int WORD_W         = 64;
   localparam int WORDS          = 4;
   localparam int WORD_IDX_W     = 2;

   // Field widths
   localparam int HEIGHT_W = 17;
   localparam int DET_W    = 16;

   // Locator walk: dense steps, then doubling steps, capped
   localparam int DENSE_STEPS = 10;
   localparam int MAX_STEPPED = 25;
   localparam int STEP_W      = 5;
   localparam int BACK_W      = 17;
   localparam int MULT_W      = 16;

   typedef enum logic [1:0] {
      OP_APPEND   = 2'd0,
      OP_COMPARE  = 2'd1,
      OP_TRUNCATE = 2'd2,
      OP_LOCATOR  = 2'd3
   } bhcs_op_type;

   typedef enum logic [1:0] {
      KIND_STATUS,
      KIND_COMPARE,
      KIND_LOCATOR
   } bhcs_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WRITE,
      S_REPLY,
      S_CREAD,
      S_CWAIT,
      S_CEVAL,
      S_CREPLY,
      S_LREAD,
      S_LWAIT,
      S_LEMIT
   } bhcs_state_type;

   // Controller to datapath
   typedef struct packed {
      logic                  cap_req;
      logic                  judge;
      logic                  wr_en;
      logic                  rd_en;
      logic [WORD_IDX_W-1:0] word;
      logic                  len_inc;
      logic                  len_set;
      logic                  mm_clear;
      logic                  mm_update;
      logic                  loc_init;
      logic                  loc_step;
      logic                  out_load;
      bhcs_kind_type         out_kind;
   } bhcs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      bhcs_op_type op;
      logic        item_first;
      logic        item_last;
      logic        append_ok;
      logic        len_zero;
      logic        in_range;
      logic        loc_more;
      logic        out_free;
   } bhcs_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/bhcs_ram.sv
`default_nettype none

module bhcs_ram #(
   parameter int WIDTH = bhcs_pkg::WORD_W,
   parameter int DEPTH = bhcs_pkg::DEF_MAX_BLOCKS * bhcs_pkg::WORDS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bhcs_dpath.sv
`default_nettype none
`include "block_hash_chain_store_macros.svh"

module bhcs_dpath #(
   parameter int MAX_BLOCKS = bhcs_pkg::DEF_MAX_BLOCKS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // request payload
   input  logic [1:0]                                 req_cmd,
   input  logic [bhcs_pkg::HEIGHT_W-1:0]              req_height,
   input  logic [bhcs_pkg::WORD_W-1:0]                req_in_hash_w0,
   input  logic [bhcs_pkg::WORD_W-1:0]                req_in_hash_w1,
   input  logic [bhcs_pkg::WORD_W-1:0]                req_in_hash_w2,
   input  logic [bhcs_pkg::WORD_W-1:0]                req_in_hash_w3,
   input  logic                                       req_item_first,
   input  logic                                       req_item_last,
   // controller link
   input  bhcs_pkg::bhcs_cmd_type                     cmd,
   output bhcs_pkg::bhcs_stat_type                    stat,
   // result channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [bhcs_pkg::WORD_W-1:0]                rsp_out_hash_w0,
   output logic [bhcs_pkg::WORD_W-1:0]                rsp_out_hash_w1,
   output logic [bhcs_pkg::WORD_W-1:0]                rsp_out_hash_w2,
   output logic [bhcs_pkg::WORD_W-1:0]                rsp_out_hash_w3,
   output logic                                       rsp_history_last,
   output logic                                       rsp_detach_required,
   output logic [bhcs_pkg::DET_W-1:0]                 rsp_detach_height,
   output logic                                       rsp_has_new_blocks,
   output logic [bhcs_pkg::HEIGHT_W-1:0]              rsp_new_block_height,
   output logic                                       rsp_status,
   output logic [bhcs_pkg::HEIGHT_W-1:0]              rsp_chain_height
);

   import bhcs_pkg::*;

   localparam int LEN_W  = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int ADDR_W = IDX_W + WORD_IDX_W;
   localparam int DEPTH  = MAX_BLOCKS * WORDS;
   localparam int CMP_W  = (LEN_W > HEIGHT_W) ? LEN_W : HEIGHT_W;

   // Captured request
   bhcs_op_type                    op_ff;
   logic [HEIGHT_W-1:0]            height_ff;
   logic [WORDS-1:0][WORD_W-1:0]   hash_ff;
   logic                           first_ff;
   logic                           last_ff;
   logic                           rej_ff;

   // Chain and compare state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              mm_seen_ff, mm_seen_in;
   logic [DET_W-1:0]  mm_height_ff, mm_height_in;

   // Memory read collection
   logic                          rd_pend_ff;
   logic [WORD_IDX_W-1:0]         rd_word_ff;
   logic [WORDS-1:0][WORD_W-1:0]  rdhash_ff;
   logic [WORD_W-1:0]             rd_data;
   logic [IDX_W-1:0]              rd_entry;
   logic [ADDR_W-1:0]             rd_addr;
   logic [ADDR_W-1:0]             wr_addr;

   // Locator walk
   logic [LEN_W-1:0]   sz_ff, sz_in;
   logic [BACK_W-1:0]  back_ff, back_in;
   logic [MULT_W-1:0]  mult_ff, mult_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [MULT_W-1:0]  mult_dbl;
   logic [CMP_W:0]     tip_sum;
   logic [LEN_W-1:0]   sz_next;
   logic [CMP_W-1:0]   loc_diff;

   // Comparisons
   logic [CMP_W-1:0]  height_x;
   logic [CMP_W-1:0]  len_x;
   logic              append_ok;
   logic              in_range;
   logic              loc_more;
   logic              differs;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [WORDS-1:0][WORD_W-1:0]  out_hash_ff;
   logic                          out_hist_ff;
   logic                          out_det_ff;
   logic [DET_W-1:0]              out_det_h_ff;
   logic                          out_new_ff;
   logic [HEIGHT_W-1:0]           out_new_h_ff;
   logic                          out_status_ff;
   logic [HEIGHT_W-1:0]           out_len_ff;
   logic [WORDS-1:0][WORD_W-1:0]  res_hash;
   logic                          res_hist;
   logic                          res_det;
   logic [DET_W-1:0]              res_det_h;
   logic                          res_new;
   logic [HEIGHT_W-1:0]           res_new_h;
   logic                          res_status;
   logic                          out_free;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         op_ff      <= bhcs_op_type'(req_cmd);
         height_ff  <= req_height;
         hash_ff    <= {req_in_hash_w3, req_in_hash_w2, req_in_hash_w1, req_in_hash_w0};
         first_ff   <= req_item_first;
         last_ff    <= req_item_last;
      end
      if (cmd.judge) begin
         rej_ff <= (op_ff == OP_APPEND) ? !append_ok : !in_range;
      end
   end

   // Range checks against the current length
   assign height_x  = CMP_W'(height_ff);
   assign len_x     = CMP_W'(len_ff);
   assign append_ok = (len_x < CMP_W'(MAX_BLOCKS)) && (height_x == len_x);
   assign in_range  = height_x < len_x;
   assign loc_more  = (CMP_W'(back_ff) < CMP_W'(sz_ff)) && (step_ff < STEP_W'(MAX_STEPPED));
   assign differs   = rdhash_ff != hash_ff;

   // Length and mismatch record
   always_comb begin
      len_in       = len_ff;
      mm_seen_in   = mm_seen_ff;
      mm_height_in = mm_height_ff;
      if (cmd.len_inc) begin
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.len_set) begin
         len_in = LEN_W'(height_ff);
      end
      if (cmd.mm_clear) begin
         mm_seen_in = 1'b0;
      end else if (cmd.mm_update && !mm_seen_ff && in_range && differs) begin
         mm_seen_in   = 1'b1;
         mm_height_in = height_ff[DET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         mm_seen_ff   <= 1'b0;
         mm_height_ff <= '0;
      end else begin
         len_ff       <= len_in;
         mm_seen_ff   <= mm_seen_in;
         mm_height_ff <= mm_height_in;
      end
   end

   // Locator start: min(local height + 1, length)
   assign tip_sum  = (CMP_W+1)'(height_ff) + (CMP_W+1)'(1);
   assign sz_next  = (tip_sum > (CMP_W+1)'(len_ff)) ? len_ff : LEN_W'(tip_sum);
   assign loc_diff = CMP_W'(sz_ff) - CMP_W'(back_ff);
   assign mult_dbl = mult_ff << 1;

   // Locator step: unit steps first, then the step size doubles
   always_comb begin
      sz_in   = sz_ff;
      back_in = back_ff;
      mult_in = mult_ff;
      step_in = step_ff;
      if (cmd.loc_init) begin
         sz_in   = sz_next;
         back_in = BACK_W'(1);
         mult_in = MULT_W'(1);
         step_in = '0;
      end else if (cmd.loc_step) begin
         step_in = step_ff + STEP_W'(1);
         if (step_ff < STEP_W'(DENSE_STEPS)) begin
            back_in = back_ff + BACK_W'(1);
         end else begin
            mult_in = mult_dbl;
            back_in = back_ff + BACK_W'(mult_dbl);
         end
      end
   end

   always_ff @(posedge clock) begin
      sz_ff   <= sz_in;
      back_ff <= back_in;
      mult_ff <= mult_in;
      step_ff <= step_in;
   end

   // Memory addressing: four words per entry
   always_comb begin
      if (op_ff == OP_COMPARE) begin
         rd_entry = height_x[IDX_W-1:0];
      end else if (loc_more) begin
         rd_entry = loc_diff[IDX_W-1:0];
      end else begin
         rd_entry = '0;
      end
   end

   assign rd_addr = {rd_entry, cmd.word};
   assign wr_addr = {len_ff[IDX_W-1:0], cmd.word};

   bhcs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (hash_ff[cmd.word]),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Collect read words the cycle after each read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
      rd_word_ff <= cmd.word;
      if (rd_pend_ff) begin
         rdhash_ff[rd_word_ff] <= rd_data;
      end
   end

   // Result contents by kind
   always_comb begin
      res_hash   = '0;
      res_hist   = 1'b0;
      res_det    = 1'b0;
      res_det_h  = '0;
      res_new    = 1'b0;
      res_new_h  = '0;
      res_status = 1'b0;
      case (cmd.out_kind)
         KIND_LOCATOR: begin
            res_hash = rdhash_ff;
            res_hist = !loc_more;
         end
         KIND_COMPARE: begin
            if (mm_seen_ff) begin
               res_det   = 1'b1;
               res_det_h = mm_height_ff;
               res_new   = 1'b1;
               res_new_h = HEIGHT_W'(mm_height_ff);
            end else if (!in_range) begin
               res_new   = 1'b1;
               res_new_h = HEIGHT_W'(len_ff);
            end
         end
         default: begin
            res_status = rej_ff;
         end
      endcase
   end

   // Output register: holds while stalled
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         out_hash_ff   <= res_hash;
         out_hist_ff   <= res_hist;
         out_det_ff    <= res_det;
         out_det_h_ff  <= res_det_h;
         out_new_ff    <= res_new;
         out_new_h_ff  <= res_new_h;
         out_status_ff <= res_status;
         out_len_ff    <= HEIGHT_W'(len_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_hash_w0      = out_hash_ff[0];
   assign rsp_out_hash_w1      = out_hash_ff[1];
   assign rsp_out_hash_w2      = out_hash_ff[2];
   assign rsp_out_hash_w3      = out_hash_ff[3];
   assign rsp_history_last     = out_hist_ff;
   assign rsp_detach_required  = out_det_ff;
   assign rsp_detach_height    = out_det_h_ff;
   assign rsp_has_new_blocks   = out_new_ff;
   assign rsp_new_block_height = out_new_h_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_chain_height     = out_len_ff;

   // Status to the controller
   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.item_first = first_ff;
      stat.item_last  = last_ff;
      stat.append_ok  = append_ok;
      stat.len_zero   = (len_ff == '0);
      stat.in_range   = in_range;
      stat.loc_more   = loc_more;
      stat.out_free   = out_free;
   end

   // Length never passes capacity, and moves only on command
   `BHCS_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, CMP_W'(len_ff) <= CMP_W'(MAX_BLOCKS), "length beyond capacity")
   `BHCS_ASSERT_NEXT(a_len_hold, clock, reset, !cmd.len_inc && !cmd.len_set, $stable(len_ff), "length moved without command")

endmodule

`default_nettype wire

FILE: rtl/core/bhcs_ctrl.sv
`default_nettype none
`include "block_hash_chain_store_macros.svh"

module bhcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bhcs_pkg::bhcs_stat_type stat,
   output bhcs_pkg::bhcs_cmd_type  cmd
);

   import bhcs_pkg::*;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS - 1);

   bhcs_state_type         state_ff, state_in;
   logic [WORD_IDX_W-1:0]  wcnt_ff, wcnt_in;
   logic                   last_word;

   assign last_word = (wcnt_ff == LAST_WORD);

   // Next state and word counter
   always_comb begin
      state_in = state_ff;
      wcnt_in  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_APPEND:   state_in = stat.append_ok ? S_WRITE : S_REPLY;
               OP_TRUNCATE: state_in = S_REPLY;
               OP_COMPARE:  state_in = stat.in_range ? S_CREAD : S_CEVAL;
               OP_LOCATOR:  state_in = stat.len_zero ? S_IDLE : S_LREAD;
               default:     state_in = S_IDLE;
            endcase
         end
         S_WRITE: begin
            wcnt_in = wcnt_ff + WORD_IDX_W'(1);
            if (last_word) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_CREAD: begin
            wcnt_in = wcnt_ff + WORD_IDX_W'(1);
            if (last_word) begin
               state_in = S_CWAIT;
            end
         end
         S_CWAIT: state_in = S_CEVAL;
         S_CEVAL: state_in = stat.item_last ? S_CREPLY : S_IDLE;
         S_CREPLY: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_LREAD: begin
            wcnt_in = wcnt_ff + WORD_IDX_W'(1);
            if (last_word) begin
               state_in = S_LWAIT;
            end
         end
         S_LWAIT: state_in = S_LEMIT;
         S_LEMIT: begin
            if (stat.out_free) begin
               state_in = stat.loc_more ? S_LREAD : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wcnt_ff  <= wcnt_in;
      end
   end

   // Datapath commands
   always_comb begin
      cmd          = '0;
      cmd.out_kind = KIND_STATUS;
      cmd.word     = wcnt_ff;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.cap_req = req_valid;
         end
         S_DECODE: begin
            cmd.judge    = 1'b1;
            cmd.len_set  = (stat.op == OP_TRUNCATE) && stat.in_range;
            cmd.mm_clear = (stat.op == OP_COMPARE) && stat.item_first;
            cmd.loc_init = (stat.op == OP_LOCATOR);
         end
         S_WRITE: begin
            cmd.wr_en   = 1'b1;
            cmd.len_inc = last_word;
         end
         S_REPLY: begin
            cmd.out_load = stat.out_free;
         end
         S_CREAD, S_LREAD: begin
            cmd.rd_en = 1'b1;
         end
         S_CEVAL: begin
            cmd.mm_update = 1'b1;
         end
         S_CREPLY: begin
            cmd.out_kind = KIND_COMPARE;
            cmd.out_load = stat.out_free;
            cmd.mm_clear = stat.out_free;
         end
         S_LEMIT: begin
            cmd.out_kind = KIND_LOCATOR;
            cmd.out_load = stat.out_free;
            cmd.loc_step = stat.out_free && stat.loc_more;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // A waiting result is never overwritten; writes only for a legal append
   `BHCS_ASSERT_NOW(a_load_free, clock, reset, cmd.out_load, stat.out_free, "result overwritten")
   `BHCS_ASSERT_NOW(a_write_legal, clock, reset, cmd.wr_en, stat.append_ok && (stat.op == OP_APPEND), "store write outside append")

endmodule

`default_nettype wire

FILE: rtl/core/block_hash_chain_store.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   cmd, height, in_hash_w0..w3, item_first/last
// rsp_      out        rsp_valid/rsp_stall   out_hash_w0..w3, compare report, status, height
//
// Each request: accept, decode. Append: four word writes on the store port, reply; none if
// rejected. Truncate: reply. Compare: four reads, read wait, evaluate, report on the last
// item; no reads past the store. Locator: four reads, wait, emit per hash; up to 26 hashes.
// Reset clears length and mismatch record at once; the store needs no clearing pass.
// rsp_stall holds the result register; a new request is taken while a result waits,
// and work stops only when the next result is ready to load.
`default_nettype none

module block_hash_chain_store #(
   parameter int MAX_BLOCKS = bhcs_pkg::DEF_MAX_BLOCKS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [bhcs_pkg::HEIGHT_W-1:0]    req_height,
   input  logic [bhcs_pkg::WORD_W-1:0]      req_in_hash_w0,
   input  logic [bhcs_pkg::WORD_W-1:0]      req_in_hash_w1,
   input  logic [bhcs_pkg::WORD_W-1:0]      req_in_hash_w2,
   input  logic [bhcs_pkg::WORD_W-1:0]      req_in_hash_w3,
   input  logic                             req_item_first,
   input  logic                             req_item_last,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bhcs_pkg::WORD_W-1:0]      rsp_out_hash_w0,
   output logic [bhcs_pkg::WORD_W-1:0]      rsp_out_hash_w1,
   output logic [bhcs_pkg::WORD_W-1:0]      rsp_out_hash_w2,
   output logic [bhcs_pkg::WORD_W-1:0]      rsp_out_hash_w3,
   output logic                             rsp_history_last,
   output logic                             rsp_detach_required,
   output logic [bhcs_pkg::DET_W-1:0]       rsp_detach_height,
   output logic                             rsp_has_new_blocks,
   output logic [bhcs_pkg::HEIGHT_W-1:0]    rsp_new_block_height,
   output logic                             rsp_status,
   output logic [bhcs_pkg::HEIGHT_W-1:0]    rsp_chain_height
);

   import bhcs_pkg::*;

   bhcs_cmd_type  cmd;
   bhcs_stat_type stat;

   // Sequencer
   bhcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, compare, locator walk and result register
   bhcs_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .req_cmd              (req_cmd),
      .req_height           (req_height),
      .req_in_hash_w0       (req_in_hash_w0),
      .req_in_hash_w1       (req_in_hash_w1),
      .req_in_hash_w2       (req_in_hash_w2),
      .req_in_hash_w3       (req_in_hash_w3),
      .req_item_first       (req_item_first),
      .req_item_last        (req_item_last),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_hash_w0      (rsp_out_hash_w0),
      .rsp_out_hash_w1      (rsp_out_hash_w1),
      .rsp_out_hash_w2      (rsp_out_hash_w2),
      .rsp_out_hash_w3      (rsp_out_hash_w3),
      .rsp_history_last     (rsp_history_last),
      .rsp_detach_required  (rsp_detach_required),
      .rsp_detach_height    (rsp_detach_height),
      .rsp_has_new_blocks   (rsp_has_new_blocks),
      .rsp_new_block_height (rsp_new_block_height),
      .rsp_status           (rsp_status),
      .rsp_chain_height     (rsp_chain_height)
   );

endmodule

`default_nettype wire
